// ----- design/assert_macros.svh -----
// assertion macros for the send window ack tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/swat_pkg.sv -----
// package with codes and defaults for the send window ack tracker
package swat_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int PKT_BYTES_DEF = 1024;

  localparam int REQ_W    = 3;
  localparam int SEQ_W    = 14;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 4;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [REQ_W-1:0] REQ_SEND   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ACK    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CUMACK = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SHIFT  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_PENDING = 2'd3;

  localparam logic REG_WINDOW_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

endpackage

// ----- design/swat_ring_unit.sv -----
// shared ring arithmetic unit: modular distance and modular increment
module swat_ring_unit #(
  parameter int SLOTS  = swat_pkg::SLOTS_DEF,
  parameter int SLOT_W = $clog2(SLOTS)
) (
  input  logic [SLOT_W-1:0] a_i,
  input  logic [SLOT_W-1:0] b_i,
  output logic [SLOT_W-1:0] dist_o,
  output logic [SLOT_W-1:0] inc_o
);

  localparam logic [SLOT_W:0] RING = (SLOT_W+1)'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

  logic [SLOT_W:0] wrap_sum;
  logic [SLOT_W:0] plain_diff;

  assign plain_diff = {1'b0, b_i} - {1'b0, a_i};
  assign wrap_sum   = {1'b0, b_i} + RING - {1'b0, a_i};
  assign dist_o     = (b_i >= a_i) ? plain_diff[SLOT_W-1:0] : wrap_sum[SLOT_W-1:0];
  assign inc_o      = (a_i == LAST) ? '0 : a_i + SLOT_W'(1);

endmodule

// ----- design/send_window_ack_tracker.sv -----
// top level of the send window ack tracker: sequencer, ack flag memory, apb register
//
// channel   direction  handshake                      payload
// request   in         start && !busy                 req_type_i, seq_i
// result    out        done_o, one cycle, no stall    status_o .. started_o
// config    in         psel && penable && pwrite      paddr, pwdata (prdata on read)
//
// a request passes S_DIST and S_EXEC, then S_ACK1 for a single ack, S_LOOK for an
// in-window lookup or an S_CRD, S_CWR read and write pair per slot for a cumulative
// ack, then S_WINIT and the oldest-unacked walk, an S_WRD, S_WCK pair per slot up to
// the first unacked one (at most SLOTS-1 acked slots passed), before its result strobe;
// the ack flag memory read port is registered. busy is raised by the accept and stays
// high until the strobe cycle, where the next request may already be taken. reset
// empties the window at once: no clearing pass, slots outside the window read as empty.
module send_window_ack_tracker #(
  parameter int SLOTS     = swat_pkg::SLOTS_DEF,
  parameter int PKT_BYTES = swat_pkg::PKT_BYTES_DEF,
  parameter int SLOT_W    = $clog2(SLOTS),
  parameter int CNT_W     = $clog2(SLOTS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [swat_pkg::REQ_W-1:0]      req_type_i,
  input  logic [swat_pkg::SEQ_W-1:0]      seq_i,
  output logic                            done_o,
  output logic [swat_pkg::STATUS_W-1:0]   status_o,
  output logic [SLOT_W-1:0]               slot_o,
  output logic [CNT_W-1:0]                pending_count_o,
  output logic [CNT_W-1:0]                acked_count_o,
  output logic [SLOT_W-1:0]               oldest_unacked_slot_o,
  output logic                            oldest_valid_o,
  output logic                            started_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swat_pkg::APB_AW-1:0]     paddr,
  input  logic [swat_pkg::APB_DW-1:0]     pwdata,
  output logic [swat_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import swat_pkg::*;

  `include "assert_macros.svh"

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] S_DIST  = 4'd1;
  localparam logic [ST_W-1:0] S_EXEC  = 4'd2;
  localparam logic [ST_W-1:0] S_ACK1  = 4'd3;
  localparam logic [ST_W-1:0] S_LOOK  = 4'd4;
  localparam logic [ST_W-1:0] S_CRD   = 4'd5;
  localparam logic [ST_W-1:0] S_CWR   = 4'd6;
  localparam logic [ST_W-1:0] S_WINIT = 4'd7;
  localparam logic [ST_W-1:0] S_WRD   = 4'd8;
  localparam logic [ST_W-1:0] S_WCK   = 4'd9;

  localparam int CMP_W = (SLOT_W > LIMIT_W) ? SLOT_W : LIMIT_W;
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

  logic [ST_W-1:0]     state_q, state_d;
  logic [REQ_W-1:0]    req_q, req_d;
  logic [SLOT_W-1:0]   addr_q, addr_d;
  logic [SLOT_W-1:0]   dist_q, dist_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [SLOT_W-1:0]   start_slot_q, start_slot_d;
  logic [SLOT_W-1:0]   next_slot_q, next_slot_d;
  logic [SLOT_W-1:0]   outs_q, outs_d;
  logic [CNT_W-1:0]    acked_q, acked_d;
  logic                started_q, started_d;
  logic [LIMIT_W-1:0]  limit_q;
  logic                done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [SLOT_W-1:0]   oldest_q, oldest_d;
  logic                valid_q, valid_d;

  logic                acked_mem_q [SLOTS];
  logic                rd_data_q;
  logic [SLOT_W-1:0]   rd_addr;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  logic                wr_data;

  logic [SLOT_W-1:0]   alu_a, alu_b, alu_dist, alu_inc;
  logic                accept;
  logic                full;
  logic                in_window;
  logic                cfg_write;
  logic [SLOT_W-1:0]   seq_addr;

  swat_ring_unit #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_ring (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .dist_o (alu_dist),
    .inc_o  (alu_inc)
  );

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);
  assign seq_addr  = SLOT_W'((int'(seq_i) / PKT_BYTES) % SLOTS);
  assign full      = (CMP_W'(outs_q) >= CMP_W'(limit_q)) || (outs_q == LAST);
  assign in_window = (dist_q < outs_q);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    addr_d       = addr_q;
    dist_d       = dist_q;
    idx_d        = idx_q;
    start_slot_d = start_slot_q;
    next_slot_d  = next_slot_q;
    outs_d       = outs_q;
    acked_d      = acked_q;
    started_d    = started_q;
    done_d       = 1'b0;
    status_d     = status_q;
    slot_d       = slot_q;
    oldest_d     = oldest_q;
    valid_d      = valid_q;
    alu_a        = start_slot_q;
    alu_b        = addr_q;
    rd_addr      = idx_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = req_type_i;
          addr_d  = seq_addr;
          state_d = S_DIST;
        end
      end
      S_DIST: begin
        dist_d  = alu_dist;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        status_d = ST_OK;
        slot_d   = addr_q;
        rd_addr  = addr_q;
        alu_a    = next_slot_q;
        state_d  = S_WINIT;
        case (req_q)
          REQ_SEND: begin
            slot_d = next_slot_q;
            if (full) begin
              status_d = ST_FULL;
            end else begin
              wr_en       = 1'b1;
              wr_addr     = next_slot_q;
              wr_data     = 1'b0;
              next_slot_d = alu_inc;
              outs_d      = outs_q + SLOT_W'(1);
              started_d   = 1'b1;
            end
          end
          REQ_ACK: begin
            if (in_window) begin
              state_d = S_ACK1;
            end else begin
              status_d = ST_OUTSIDE;
            end
          end
          REQ_CUMACK: begin
            if (in_window) begin
              idx_d   = start_slot_q;
              state_d = S_CRD;
            end else begin
              status_d = ST_OUTSIDE;
            end
          end
          REQ_LOOKUP: begin
            if (in_window) begin
              state_d = S_LOOK;
            end else begin
              status_d = ST_NOT_PENDING;
            end
          end
          REQ_SHIFT: begin
            slot_d       = '0;
            start_slot_d = next_slot_q;
            outs_d       = '0;
            acked_d      = '0;
          end
          default: begin
            slot_d = '0;
          end
        endcase
      end
      S_ACK1: begin
        wr_en   = 1'b1;
        wr_addr = addr_q;
        if (!rd_data_q) begin
          acked_d = acked_q + CNT_W'(1);
        end
        state_d = S_WINIT;
      end
      S_LOOK: begin
        status_d = rd_data_q ? ST_NOT_PENDING : ST_OK;
        state_d  = S_WINIT;
      end
      S_CRD: begin
        state_d = S_CWR;
      end
      S_CWR: begin
        wr_en = 1'b1;
        alu_a = idx_q;
        if (!rd_data_q) begin
          acked_d = acked_q + CNT_W'(1);
        end
        if (idx_q == addr_q) begin
          state_d = S_WINIT;
        end else begin
          idx_d   = alu_inc;
          state_d = S_CRD;
        end
      end
      S_WINIT: begin
        idx_d   = start_slot_q;
        state_d = S_WRD;
      end
      S_WRD: begin
        if (idx_q == next_slot_q) begin
          oldest_d = '0;
          valid_d  = 1'b0;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_WCK;
        end
      end
      S_WCK: begin
        alu_a = idx_q;
        if (rd_data_q) begin
          idx_d   = alu_inc;
          state_d = S_WRD;
        end else begin
          oldest_d = idx_q;
          valid_d  = 1'b1;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      start_slot_q <= '0;
      next_slot_q  <= '0;
      outs_q       <= '0;
      acked_q      <= '0;
      started_q    <= 1'b0;
      done_q       <= 1'b0;
      limit_q      <= LIMIT_RESET;
    end else begin
      state_q      <= state_d;
      start_slot_q <= start_slot_d;
      next_slot_q  <= next_slot_d;
      outs_q       <= outs_d;
      acked_q      <= acked_d;
      started_q    <= started_d;
      done_q       <= done_d;
      if (cfg_write && (paddr[2] == REG_WINDOW_LIMIT)) begin
        limit_q <= pwdata[LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    addr_q   <= addr_d;
    dist_q   <= dist_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    oldest_q <= oldest_d;
    valid_q  <= valid_d;
  end

  // ack flags, one bit per slot; a slot's flag is cleared when it is sent
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      acked_mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= acked_mem_q[rd_addr];
  end

  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_WINDOW_LIMIT) ? APB_DW'(limit_q) : '0;

  assign done_o                = done_q;
  assign status_o              = status_q;
  assign slot_o                = slot_q;
  assign pending_count_o       = CNT_W'(outs_q) - acked_q;
  assign acked_count_o         = acked_q;
  assign oldest_unacked_slot_o = oldest_q;
  assign oldest_valid_o        = valid_q;
  assign started_o             = started_q;

  `ASSERT_SAME(a_done_idle, done_q, state_q == S_IDLE, "result beat while sequencer active")
  `ASSERT_SAME(a_acked_le_outs, 1'b1, acked_q <= CNT_W'(outs_q), "acked count exceeds window")
  `ASSERT_NEXT(a_accept_busy, accept, busy && (state_q == S_DIST), "accepted request not started")
  `ASSERT_SAME(a_oldest_pending, done_q && valid_q, pending_count_o != '0, "oldest valid with none pending")

endmodule
